// ===== rtl/spf_pkg.sv =====
// ----------------------------------------------------------------------------
// Sensor packet framer package
// Shared types, constants and the CRC-8 byte update function.
// ----------------------------------------------------------------------------
package spf_pkg;

  localparam logic [7:0] PKT_HEADER = 8'h34;
  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] BATTERY_RESET = 8'h4B;
  localparam logic signed [11:0] TEMP_MIN = -12'sd400;
  localparam logic signed [11:0] TEMP_MAX = 12'sd600;
  localparam logic [11:0] TEMP_OFFSET = 12'd400;
  localparam logic [3:0] SUBTYPE = 4'h0;
  localparam int unsigned PKT_LEN = 9;
  localparam logic [3:0] LAST_IDX = 4'(PKT_LEN - 1);

  localparam logic [1:0] STATUS_OK = 2'd0;
  localparam logic [1:0] STATUS_BAD_ID = 2'd1;
  localparam logic [1:0] STATUS_BAD_TEMP = 2'd2;

  typedef struct packed {
    logic [1:0]  status;
    logic [23:0] id;
    logic [11:0] raw;
    logic [7:0]  battery;
    logic [7:0]  crc;
    logic [7:0]  sum;
  } frame_t;

  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int b = 0; b < 8; b++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/spf_in_if.sv =====
// ----------------------------------------------------------------------------
// Sensor sample channel
// Valid/ready channel carrying one sensor reading per request.
// ----------------------------------------------------------------------------
interface spf_in_if;
  logic               valid;
  logic               ready;
  logic [31:0]        sensor_id;
  logic signed [11:0] temp_tenths;

  modport source (output valid, output sensor_id, output temp_tenths, input ready);
  modport sink (input valid, input sensor_id, input temp_tenths, output ready);
endinterface

// ===== rtl/spf_out_if.sv =====
// ----------------------------------------------------------------------------
// Packet byte channel
// Valid/ready channel carrying one packet byte with status and last flag.
// ----------------------------------------------------------------------------
interface spf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] status;
  logic       last;

  modport source (output valid, output out_byte, output status, output last, input ready);
  modport sink (input valid, input out_byte, input status, input last, output ready);
endinterface

// ===== rtl/spf_cfg_if.sv =====
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel carrying the battery register write data.
// ----------------------------------------------------------------------------
interface spf_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/spf_check.sv =====
// ----------------------------------------------------------------------------
// Sensor packet framer input stage
// Registers each request, checks the ID and temperature range and offsets
// the temperature.
// ----------------------------------------------------------------------------
module spf_check (
  input  logic            clk,
  input  logic            rst,
  spf_in_if.sink          sample,
  input  logic [7:0]      battery,
  output logic            dn_valid,
  input  logic            dn_ready,
  output spf_pkg::frame_t dn_frame
);
  import spf_pkg::*;

  logic   en;
  frame_t frame_next;

  assign en = !dn_valid || dn_ready;
  assign sample.ready = en;

  always_comb begin
    frame_next = '0;
    frame_next.id = sample.sensor_id[23:0];
    frame_next.raw = sample.temp_tenths + TEMP_OFFSET;
    frame_next.battery = battery;
    if (sample.sensor_id[31:24] != 8'h00) begin
      frame_next.status = STATUS_BAD_ID;
    end else if (sample.temp_tenths < TEMP_MIN || sample.temp_tenths > TEMP_MAX) begin
      frame_next.status = STATUS_BAD_TEMP;
    end else begin
      frame_next.status = STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (en) begin
      dn_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && sample.valid) begin
      dn_frame <= frame_next;
    end
  end

endmodule

// ===== rtl/spf_crc.sv =====
// ----------------------------------------------------------------------------
// Sensor packet framer checksum stages
// Two register stages: CRC-8 and byte sum over the header and ID bytes,
// then over the temperature and battery bytes.
// ----------------------------------------------------------------------------
module spf_crc (
  input  logic            clk,
  input  logic            rst,
  input  logic            up_valid,
  output logic            up_ready,
  input  spf_pkg::frame_t up_frame,
  output logic            dn_valid,
  input  logic            dn_ready,
  output spf_pkg::frame_t dn_frame
);
  import spf_pkg::*;

  logic   mid_valid;
  frame_t mid_frame;
  logic   en_mid;
  logic   en_dn;
  frame_t mid_next;
  frame_t dn_next;
  logic [7:0] temp_hi;

  assign en_dn = !dn_valid || dn_ready;
  assign en_mid = !mid_valid || en_dn;
  assign up_ready = en_mid;

  always_comb begin
    mid_next = up_frame;
    mid_next.crc = crc8_update(crc8_update(crc8_update(crc8_update(8'h00, PKT_HEADER),
      up_frame.id[23:16]), up_frame.id[15:8]), up_frame.id[7:0]);
    mid_next.sum = PKT_HEADER + up_frame.id[23:16] + up_frame.id[15:8] + up_frame.id[7:0];
  end

  assign temp_hi = {SUBTYPE, mid_frame.raw[11:8]};

  always_comb begin
    dn_next = mid_frame;
    dn_next.crc = crc8_update(crc8_update(crc8_update(mid_frame.crc, temp_hi),
      mid_frame.raw[7:0]), mid_frame.battery);
    dn_next.sum = mid_frame.sum + temp_hi + mid_frame.raw[7:0] + mid_frame.battery;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
      dn_valid <= 1'b0;
    end else begin
      if (en_mid) begin
        mid_valid <= up_valid;
      end
      if (en_dn) begin
        dn_valid <= mid_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_mid && up_valid) begin
      mid_frame <= mid_next;
    end
    if (en_dn && mid_valid) begin
      dn_frame <= dn_next;
    end
  end

endmodule

// ===== rtl/spf_serial.sv =====
// ----------------------------------------------------------------------------
// Sensor packet framer serializer
// Holds one finished frame and sends it one byte per request, or sends a
// single status request for a rejected sample.
// ----------------------------------------------------------------------------
module spf_serial (
  input  logic            clk,
  input  logic            rst,
  input  logic            up_valid,
  output logic            up_ready,
  input  spf_pkg::frame_t up_frame,
  spf_out_if.source       pkt
);
  import spf_pkg::*;

  logic       busy;
  logic [3:0] idx;
  frame_t     frame;
  frame_t     frame_in;
  logic       is_err;
  logic       fire;
  logic [7:0] byte_sel;

  assign is_err = frame.status != STATUS_OK;
  assign fire = pkt.valid && pkt.ready;
  assign up_ready = !busy || (fire && pkt.last);

  always_comb begin
    frame_in = up_frame;
    frame_in.sum = up_frame.sum + up_frame.crc;
  end

  always_comb begin
    case (idx)
      4'd0: byte_sel = PKT_HEADER;
      4'd1: byte_sel = frame.id[23:16];
      4'd2: byte_sel = frame.id[15:8];
      4'd3: byte_sel = frame.id[7:0];
      4'd4: byte_sel = {SUBTYPE, frame.raw[11:8]};
      4'd5: byte_sel = frame.raw[7:0];
      4'd6: byte_sel = frame.battery;
      4'd7: byte_sel = frame.crc;
      4'd8: byte_sel = frame.sum;
      default: byte_sel = 8'h00;
    endcase
  end

  assign pkt.valid = busy;
  assign pkt.out_byte = is_err ? 8'h00 : byte_sel;
  assign pkt.status = frame.status;
  assign pkt.last = is_err || (idx == LAST_IDX);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx <= 4'd0;
    end else if (fire && !pkt.last) begin
      idx <= idx + 4'd1;
    end else if (up_ready) begin
      busy <= up_valid;
      idx <= 4'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      frame <= frame_in;
    end
  end

endmodule

// ===== rtl/sensor_packet_framer.sv =====
// ----------------------------------------------------------------------------
// Sensor packet framer
// The first byte of a packet is offered once its sample has passed the check register,
// the two checksum stages and the serializer frame register. Bytes go out one per cycle while
// the output channel is ready; the next frame is taken as the last byte of a packet is accepted.
// Reset clears all pipeline valid bits and sets the battery byte to 0x4B.
// ----------------------------------------------------------------------------
module sensor_packet_framer (
  input  logic      clk,
  input  logic      rst,
  spf_in_if.sink    sample,
  spf_cfg_if.sink   cfg,
  spf_out_if.source pkt
);
  import spf_pkg::*;

  logic [7:0] battery;
  logic       chk_valid;
  logic       chk_ready;
  frame_t     chk_frame;
  logic       crc_valid;
  logic       crc_ready;
  frame_t     crc_frame;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      battery <= BATTERY_RESET;
    end else if (cfg.valid) begin
      battery <= cfg.data;
    end
  end

  spf_check u_check (
    .clk      (clk),
    .rst      (rst),
    .sample   (sample),
    .battery  (battery),
    .dn_valid (chk_valid),
    .dn_ready (chk_ready),
    .dn_frame (chk_frame)
  );

  spf_crc u_crc (
    .clk      (clk),
    .rst      (rst),
    .up_valid (chk_valid),
    .up_ready (chk_ready),
    .up_frame (chk_frame),
    .dn_valid (crc_valid),
    .dn_ready (crc_ready),
    .dn_frame (crc_frame)
  );

  spf_serial u_serial (
    .clk      (clk),
    .rst      (rst),
    .up_valid (crc_valid),
    .up_ready (crc_ready),
    .up_frame (crc_frame),
    .pkt      (pkt)
  );

endmodule
